/* rtl/todq_pkg.sv */
// Shared codes and types for the timestamp-ordered delay queue.
// No dependencies; used by todq_engine and the top level.
package todq_pkg;

  localparam int unsigned TYPE_BITS = 32;
  localparam int unsigned DELAY_BITS = 32;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_RESP
  } fsm_e;

endpackage

/* rtl/todq_cmd_fifo.sv */
// Two-entry request queue between the stream input and the engine.
// No package dependencies.
module todq_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       fill_q;
  logic             push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_data_o  = mem_q[rptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/todq_engine.sv */
// Back end: event store memory, scan sequencer and result register.
// Depends on todq_pkg.
module todq_engine #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [todq_pkg::DELAY_BITS-1:0] delay_i,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  logic                           cmd_kind_i,
  input  logic [TIME_BITS-1:0]           cmd_time_i,
  input  logic [todq_pkg::TYPE_BITS-1:0] cmd_type_i,
  input  logic [HANDLE_BITS-1:0]         cmd_handle_i,
  input  logic [TIME_BITS-1:0]           cmd_now_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output todq_pkg::status_e              res_status_o,
  output logic [TIME_BITS-1:0]           res_time_o,
  output logic [todq_pkg::TYPE_BITS-1:0] res_type_o,
  output logic [HANDLE_BITS-1:0]         res_handle_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned YW = todq_pkg::TYPE_BITS;
  localparam int unsigned EW = TIME_BITS + YW + HANDLE_BITS;

  todq_pkg::fsm_e state_q, state_d;

  logic [EW-1:0]          mem_q [CAPACITY];
  logic [CAPACITY-1:0]    valid_q;
  logic [CW-1:0]          held_q;

  logic                   c_kind_q;
  logic [TIME_BITS-1:0]   c_time_q, c_now_q;
  logic [YW-1:0]          c_type_q;
  logic [HANDLE_BITS-1:0] c_handle_q;

  logic [AW-1:0]          cnt_q;
  logic                   rd_live_q, rd_vld_q;
  logic [AW-1:0]          rd_idx_q;
  logic [EW-1:0]          rd_data_q;

  logic                   dup_q, free_q, best_q;
  logic [AW-1:0]          free_idx_q, best_idx_q;
  logic [TIME_BITS-1:0]   best_time_q;
  logic [YW-1:0]          best_type_q;
  logic [HANDLE_BITS-1:0] best_handle_q;

  logic                   out_valid_q;
  todq_pkg::status_e      out_status_q;
  logic [TIME_BITS-1:0]   out_time_q;
  logic [YW-1:0]          out_type_q;
  logic [HANDLE_BITS-1:0] out_handle_q;

  todq_pkg::status_e      pend_status_q;

  logic [TIME_BITS-1:0]   rd_time;
  logic [YW-1:0]          rd_type;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   rd_earlier, ready_chk, out_free, accept, do_write;
  logic                   scan_en;

  assign rd_time   = rd_data_q[TIME_BITS-1:0];
  assign rd_type   = rd_data_q[TIME_BITS +: YW];
  assign rd_handle = rd_data_q[TIME_BITS+YW +: HANDLE_BITS];

  assign rd_earlier = (rd_time < best_time_q) ||
                      ((rd_time == best_time_q) && (rd_handle < best_handle_q));
  assign ready_chk  = ({1'b0, best_time_q} + (TIME_BITS + 1)'(delay_i)) <=
                      {1'b0, c_now_q};
  assign out_free   = !out_valid_q || res_ready_i;
  assign accept     = cmd_valid_i && cmd_ready_o;
  assign do_write   = (state_q == todq_pkg::S_DECIDE) && (c_kind_q == todq_pkg::KIND_ADD)
                      && !dup_q && free_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      todq_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_kind_i == todq_pkg::KIND_POLL && held_q == '0) state_d = todq_pkg::S_RESP;
          else state_d = todq_pkg::S_SCAN;
        end
      end
      todq_pkg::S_SCAN: begin
        if (cnt_q == AW'(CAPACITY - 1)) state_d = todq_pkg::S_DRAIN;
      end
      todq_pkg::S_DRAIN:  state_d = todq_pkg::S_DECIDE;
      todq_pkg::S_DECIDE: state_d = todq_pkg::S_RESP;
      todq_pkg::S_RESP: begin
        if (out_free) state_d = todq_pkg::S_IDLE;
      end
      default: state_d = todq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready_o = (state_q == todq_pkg::S_IDLE);
    scan_en     = (state_q == todq_pkg::S_SCAN);
  end

  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_time_o   = out_time_q;
  assign res_type_o   = out_type_q;
  assign res_handle_o = out_handle_q;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[free_idx_q] <= {c_handle_q, c_type_q, c_time_q};
    end
    rd_data_q <= mem_q[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= todq_pkg::S_IDLE;
      valid_q     <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      rd_live_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_live_q <= scan_en;
      if (accept)  cnt_q <= '0;
      if (scan_en) cnt_q <= cnt_q + AW'(1);
      if (do_write) begin
        valid_q[free_idx_q] <= 1'b1;
        held_q <= held_q + CW'(1);
      end
      if (state_q == todq_pkg::S_DECIDE && c_kind_q == todq_pkg::KIND_POLL && ready_chk) begin
        valid_q[best_idx_q] <= 1'b0;
        held_q <= held_q - CW'(1);
      end
      if (res_ready_i) out_valid_q <= 1'b0;
      if (state_q == todq_pkg::S_RESP && out_free) out_valid_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_vld_q <= valid_q[cnt_q];
    rd_idx_q <= cnt_q;
    if (accept) begin
      c_kind_q      <= cmd_kind_i;
      c_time_q      <= cmd_time_i;
      c_type_q      <= cmd_type_i;
      c_handle_q    <= cmd_handle_i;
      c_now_q       <= cmd_now_i;
      dup_q         <= 1'b0;
      free_q        <= 1'b0;
      best_q        <= 1'b0;
      pend_status_q <= todq_pkg::ST_NONE;
      best_time_q   <= '0;
      best_type_q   <= '0;
      best_handle_q <= '0;
    end
    if (rd_live_q) begin
      if (rd_vld_q && rd_time == c_time_q && rd_handle == c_handle_q) dup_q <= 1'b1;
      if (!rd_vld_q && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (rd_vld_q && (!best_q || rd_earlier)) begin
        best_q        <= 1'b1;
        best_idx_q    <= rd_idx_q;
        best_time_q   <= rd_time;
        best_type_q   <= rd_type;
        best_handle_q <= rd_handle;
      end
    end
    if (state_q == todq_pkg::S_DECIDE) begin
      if (c_kind_q == todq_pkg::KIND_ADD) begin
        pend_status_q <= (dup_q || !free_q) ? todq_pkg::ST_REJECTED : todq_pkg::ST_ADDED;
      end else begin
        pend_status_q <= ready_chk ? todq_pkg::ST_RELEASED : todq_pkg::ST_NONE;
      end
    end
    if (state_q == todq_pkg::S_RESP && out_free) begin
      out_status_q <= pend_status_q;
      if (pend_status_q == todq_pkg::ST_RELEASED) begin
        out_time_q   <= best_time_q;
        out_type_q   <= best_type_q;
        out_handle_q <= best_handle_q;
      end else begin
        out_time_q   <= '0;
        out_type_q   <= '0;
        out_handle_q <= '0;
      end
    end
  end

endmodule

/* rtl/timestamp_ordered_delay_queue.sv */
// Timestamp-ordered delay queue: top level with request queue and engine.
// Depends on todq_pkg, todq_cmd_fifo and todq_engine.
//
// Usage: requests enter on the s_axis channel. tuser is the kind (add or
// poll); tdata carries event_time, event_type, event_handle and now_time.
// Every request gives exactly one result on m_axis: tuser is the status,
// tdata carries the released event or zeros.
// cfg_we_i/cfg_wdata_i write release_delay; write only while the block is idle.
// Timing: every add and every poll of a non-empty store sweeps the event
// memory once, one entry a cycle through its single read port, before the
// result register is loaded; a poll of an empty store skips the sweep and
// goes straight to the result. A two-entry queue takes requests while the
// engine works. Reset empties the store and sets release_delay to zero;
// no clearing pass is needed. When the receiver stalls, the result is held
// in the output register and the engine waits; the input queue fills and
// then drops s_axis_tready.
module timestamp_ordered_delay_queue #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // event_time, event_type, event_handle, now_time, zero pad
  input  logic [((2*TIME_BITS+todq_pkg::TYPE_BITS+HANDLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_time, out_type, out_handle, zero pad
  output logic [((TIME_BITS+todq_pkg::TYPE_BITS+HANDLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [1:0]          m_axis_tuser
);

  localparam int unsigned YW     = todq_pkg::TYPE_BITS;
  localparam int unsigned IN_W   = 2 * TIME_BITS + YW + HANDLE_BITS;
  localparam int unsigned IN_DW  = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W  = TIME_BITS + YW + HANDLE_BITS;
  localparam int unsigned OUT_DW = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned CMD_W  = IN_W + 1;

  logic [todq_pkg::DELAY_BITS-1:0] delay_q;
  logic [CMD_W-1:0] q_data;
  logic             q_valid, q_ready;
  todq_pkg::status_e res_status;
  logic [TIME_BITS-1:0]   res_time;
  logic [YW-1:0]          res_type;
  logic [HANDLE_BITS-1:0] res_handle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  todq_cmd_fifo #(.WIDTH(CMD_W)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   ({s_axis_tdata[IN_W-1:0], s_axis_tuser}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  todq_engine #(
    .CAPACITY    (CAPACITY),
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .delay_i      (delay_q),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_kind_i   (q_data[0]),
    .cmd_time_i   (q_data[1 +: TIME_BITS]),
    .cmd_type_i   (q_data[1+TIME_BITS +: YW]),
    .cmd_handle_i (q_data[1+TIME_BITS+YW +: HANDLE_BITS]),
    .cmd_now_i    (q_data[1+TIME_BITS+YW+HANDLE_BITS +: TIME_BITS]),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (res_status),
    .res_time_o   (res_time),
    .res_type_o   (res_type),
    .res_handle_o (res_handle)
  );

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = OUT_DW'({res_handle, res_type, res_time});

endmodule
